// File: design/swr_pkg.sv
package swr_pkg;

  // Field widths
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned LEN_W   = 14;
  localparam int unsigned FLAGS_W = 3;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned SIZE_W  = 32;

  // Largest payload taken as valid
  localparam int unsigned MAX_PAYLOAD = 8192;

  // Packed stream widths, rounded up to whole bytes
  localparam int unsigned IN_BITS   = FLAGS_W + 2 * SEQ_W + LEN_W + 1 + SIZE_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS  = FLAGS_W + 2 * SEQ_W + 1 + LEN_W + 1;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int unsigned ADDR_W = 3;
  localparam logic        REG_INITIAL_SEQ   = 1'b0;
  localparam logic        REG_TIMEOUT_TICKS = 1'b1;
  localparam logic [SEQ_W-1:0]  INITIAL_SEQ_RST   = '0;
  localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd1000;

  // Packet flag codes
  localparam logic [FLAGS_W-1:0] F_NONE    = 3'b000;
  localparam logic [FLAGS_W-1:0] F_SYN     = 3'b001;
  localparam logic [FLAGS_W-1:0] F_ACK     = 3'b010;
  localparam logic [FLAGS_W-1:0] F_SYN_ACK = 3'b011;
  localparam logic [FLAGS_W-1:0] F_FIN_ACK = 3'b110;

  // Item kinds
  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef enum logic [5:0] {
    PH_LISTEN    = 6'b000001,
    PH_HANDSHAKE = 6'b000010,
    PH_WAIT_INFO = 6'b000100,
    PH_RECV_DATA = 6'b001000,
    PH_CLOSING   = 6'b010000,
    PH_CLOSED    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic               kind;
    logic [FLAGS_W-1:0] pkt_flags;
    logic [SEQ_W-1:0]   pkt_seq;
    logic [SEQ_W-1:0]   pkt_ack;
    logic [LEN_W-1:0]   pkt_length;
    logic               checksum_ok;
    logic [SIZE_W-1:0]  file_size;
  } item_t;

  typedef struct packed {
    logic [FLAGS_W-1:0] send_flags;
    logic [SEQ_W-1:0]   send_seq;
    logic [SEQ_W-1:0]   send_ack;
    logic               is_retransmit;
    logic [LEN_W-1:0]   delivered_length;
    logic               closed;
  } result_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  initial_seq;
    logic [TICK_W-1:0] timeout_ticks;
  } cfg_t;

  // Handshake between the stages
  typedef struct packed {
    logic take;   // input register hands its beat to the decision logic
  } flow_t;

endpackage

// File: design/stop_wait_receiver_connection_fsm_unit.sv
// Receiver side of a stop-and-wait link: connection state machine.
//
// Input stream (s_*): one beat is either a received packet header
// (s_tuser = 0) or one timer tick (s_tuser = 1). Output stream (m_*): the
// control packet to send (SYN+ACK, ACK or FIN+ACK), or the teardown marker
// with closed set. A beat causes at most one output beat.
//
// Configuration: APB write of initial_seq at 0x0 and timeout_ticks at 0x4;
// reads return the stored values. Write only while the block is idle.
//
// Order: a beat taken into the input register is decided combinationally and
// its result is registered in the result register, from which it leaves.
// Throughput is one beat per cycle while m_tready is high; the whole connection
// update is one compare-and-add step between the input register and the result
// register, so the state is ready for the next beat at once.
//
// Reset (rst, synchronous): phase goes to listen, all counters clear, both
// stages empty, registers take their defaults.
// Stall: while m_tready is low a waiting result holds; one more beat is taken
// into the input register, then s_tready drops until the result leaves.
module stop_wait_receiver_connection_fsm_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  // tdata: pkt_flags[2:0], pkt_seq[34:3], pkt_ack[66:35], pkt_length[80:67],
  //        checksum_ok[81], file_size[113:82], zero pad above
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [swr_pkg::IN_DATA_W-1:0]          s_tdata,
  input  logic                                   s_tuser,  // kind
  // tdata: send_flags[2:0], send_seq[34:3], send_ack[66:35],
  //        is_retransmit[67], delivered_length[81:68], closed[82], zero pad
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [swr_pkg::OUT_DATA_W-1:0]         m_tdata,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [swr_pkg::ADDR_W-1:0]             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  swr_pkg::cfg_t    cfg;
  swr_pkg::flow_t   flow;
  swr_pkg::item_t   item;
  swr_pkg::result_t res;
  logic             item_valid;
  logic             emit;
  logic             space;
  logic             cfg_wr;

  // Config registers: decode on the word address only
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_seq   <= swr_pkg::INITIAL_SEQ_RST;
      cfg.timeout_ticks <= swr_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == swr_pkg::REG_INITIAL_SEQ) begin
        cfg.initial_seq <= pwdata;
      end else begin
        cfg.timeout_ticks <= pwdata[swr_pkg::TICK_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == swr_pkg::REG_TIMEOUT_TICKS) begin
      prdata = {{(32 - swr_pkg::TICK_W){1'b0}}, cfg.timeout_ticks};
    end else begin
      prdata = cfg.initial_seq;
    end
  end

  // Advance the held beat whenever the result register has room
  assign flow.take  = item_valid && space;

  swr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .flow       (flow),
    .item_valid (item_valid),
    .item       (item)
  );

  swr_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .take (flow.take),
    .item (item),
    .cfg  (cfg),
    .emit (emit),
    .res  (res)
  );

  swr_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .take     (flow.take),
    .emit     (emit),
    .res      (res),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: design/swr_in_stage.sv
module swr_in_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [swr_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic                                s_tuser,
  input  swr_pkg::flow_t                      flow,
  output logic                                item_valid,
  output swr_pkg::item_t                      item
);

  logic valid;

  // Refill when empty or whenever the held beat moves on
  assign s_tready   = !valid || flow.take;
  assign item_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.kind        <= s_tuser;
      item.pkt_flags   <= s_tdata[2:0];
      item.pkt_seq     <= s_tdata[34:3];
      item.pkt_ack     <= s_tdata[66:35];
      item.pkt_length  <= s_tdata[80:67];
      item.checksum_ok <= s_tdata[81];
      item.file_size   <= s_tdata[113:82];
    end
  end

endmodule

// File: design/swr_fsm.sv
module swr_fsm (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  swr_pkg::item_t    item,
  input  swr_pkg::cfg_t     cfg,
  output logic              emit,
  output swr_pkg::result_t  res
);

  swr_pkg::phase_t                phase, phase_next;
  logic [swr_pkg::SEQ_W-1:0]      own_seq, own_seq_next;
  logic [swr_pkg::SEQ_W-1:0]      expected_seq, expected_seq_next;
  logic [swr_pkg::SIZE_W-1:0]     bytes_remaining, bytes_remaining_next;
  logic [swr_pkg::TICK_W-1:0]     tick_count, tick_count_next;

  logic                           pkt_ok;
  logic [swr_pkg::SEQ_W-1:0]      len_ext;
  logic [swr_pkg::SEQ_W-1:0]      seq_plus1;
  logic [swr_pkg::SEQ_W-1:0]      seq_plus_len;
  logic [swr_pkg::SEQ_W-1:0]      exp_plus_len;
  logic [swr_pkg::SEQ_W-1:0]      own_plus1;
  logic [swr_pkg::SEQ_W-1:0]      own_minus1;
  logic [swr_pkg::TICK_W-1:0]     tick_inc;
  logic                           seq_eq, seq_lt, seq_prev;
  logic [swr_pkg::SIZE_W-1:0]     left_after;

  assign len_ext      = {{(swr_pkg::SEQ_W - swr_pkg::LEN_W){1'b0}}, item.pkt_length};
  assign pkt_ok       = item.checksum_ok && (len_ext <= 32'(swr_pkg::MAX_PAYLOAD));
  assign seq_plus1    = item.pkt_seq + 32'd1;
  assign seq_plus_len = item.pkt_seq + len_ext;
  assign exp_plus_len = expected_seq + len_ext;
  assign own_plus1    = own_seq + 32'd1;
  assign own_minus1   = own_seq - 32'd1;
  assign tick_inc     = tick_count + 16'd1;
  assign seq_eq       = item.pkt_seq == expected_seq;
  assign seq_lt       = item.pkt_seq < expected_seq;
  // seq == expected - 1, modulo 2^32
  assign seq_prev     = seq_plus1 == expected_seq;
  assign left_after   = (bytes_remaining > len_ext) ? bytes_remaining - len_ext : '0;

  always_comb begin
    phase_next           = phase;
    own_seq_next         = own_seq;
    expected_seq_next    = expected_seq;
    bytes_remaining_next = bytes_remaining;
    tick_count_next      = tick_count;
    emit                 = 1'b0;
    res                  = '0;

    if (item.kind == swr_pkg::KIND_TICK) begin
      if (phase == swr_pkg::PH_CLOSING) begin
        tick_count_next = tick_inc;
        if (tick_inc >= cfg.timeout_ticks) begin
          tick_count_next   = '0;
          emit              = 1'b1;
          res.send_flags    = swr_pkg::F_FIN_ACK;
          res.send_seq      = own_seq;
          res.send_ack      = expected_seq;
          res.is_retransmit = 1'b1;
        end
      end
    end else if (pkt_ok) begin
      case (phase)
        swr_pkg::PH_LISTEN: begin
          if (item.pkt_flags == swr_pkg::F_SYN) begin
            expected_seq_next = seq_plus1;
            own_seq_next      = cfg.initial_seq + 32'd1;
            phase_next        = swr_pkg::PH_HANDSHAKE;
            emit              = 1'b1;
            res.send_flags    = swr_pkg::F_SYN_ACK;
            res.send_seq      = cfg.initial_seq;
            res.send_ack      = seq_plus1;
          end
        end
        swr_pkg::PH_HANDSHAKE: begin
          if (item.pkt_flags == swr_pkg::F_ACK && seq_eq) begin
            phase_next     = swr_pkg::PH_WAIT_INFO;
            emit           = 1'b1;
            res.send_flags = swr_pkg::F_ACK;
            res.send_seq   = own_seq;
            res.send_ack   = expected_seq;
          end else if (item.pkt_flags == swr_pkg::F_SYN && seq_prev) begin
            emit              = 1'b1;
            res.send_flags    = swr_pkg::F_SYN_ACK;
            res.send_seq      = own_minus1;
            res.send_ack      = seq_plus1;
            res.is_retransmit = 1'b1;
          end
        end
        swr_pkg::PH_WAIT_INFO: begin
          if (seq_eq && item.pkt_flags == swr_pkg::F_FIN_ACK) begin
            expected_seq_next = seq_plus1;
            tick_count_next   = '0;
            phase_next        = swr_pkg::PH_CLOSING;
            emit              = 1'b1;
            res.send_flags    = swr_pkg::F_FIN_ACK;
            res.send_seq      = own_seq;
            res.send_ack      = seq_plus1;
          end else if (seq_eq && item.pkt_length != '0) begin
            // Info packet: announce the file and start counting it down
            expected_seq_next    = exp_plus_len;
            bytes_remaining_next = item.file_size;
            phase_next           = (item.file_size == '0) ? swr_pkg::PH_WAIT_INFO
                                                          : swr_pkg::PH_RECV_DATA;
            emit                 = 1'b1;
            res.send_flags       = swr_pkg::F_ACK;
            res.send_seq         = own_seq;
            res.send_ack         = exp_plus_len;
          end else if (seq_lt) begin
            emit              = 1'b1;
            res.send_flags    = swr_pkg::F_ACK;
            res.send_seq      = own_seq;
            res.send_ack      = seq_plus1;
            res.is_retransmit = 1'b1;
          end
        end
        swr_pkg::PH_RECV_DATA: begin
          if (seq_eq && item.pkt_length != '0) begin
            bytes_remaining_next = left_after;
            expected_seq_next    = exp_plus_len;
            if (left_after == '0) begin
              phase_next = swr_pkg::PH_WAIT_INFO;
            end
            emit                 = 1'b1;
            res.send_flags       = swr_pkg::F_ACK;
            res.send_seq         = own_seq;
            res.send_ack         = exp_plus_len;
            res.delivered_length = item.pkt_length;
          end else if (seq_lt) begin
            emit              = 1'b1;
            res.send_flags    = swr_pkg::F_ACK;
            res.send_seq      = own_seq;
            res.send_ack      = seq_plus_len;
            res.is_retransmit = 1'b1;
          end
        end
        swr_pkg::PH_CLOSING: begin
          if (item.pkt_flags == swr_pkg::F_FIN_ACK && seq_prev) begin
            tick_count_next   = '0;
            emit              = 1'b1;
            res.send_flags    = swr_pkg::F_FIN_ACK;
            res.send_seq      = own_seq;
            res.send_ack      = expected_seq;
            res.is_retransmit = 1'b1;
          end else if (item.pkt_flags == swr_pkg::F_ACK && seq_eq
                       && item.pkt_ack == own_plus1) begin
            own_seq_next = own_plus1;
            phase_next   = swr_pkg::PH_CLOSED;
            emit         = 1'b1;
            res.closed   = 1'b1;
          end
        end
        default: begin
          // closed: drop everything
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= swr_pkg::PH_LISTEN;
      own_seq         <= '0;
      expected_seq    <= '0;
      bytes_remaining <= '0;
      tick_count      <= '0;
    end else if (take) begin
      phase           <= phase_next;
      own_seq         <= own_seq_next;
      expected_seq    <= expected_seq_next;
      bytes_remaining <= bytes_remaining_next;
      tick_count      <= tick_count_next;
    end
  end

endmodule

// File: design/swr_out_stage.sv
module swr_out_stage (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             take,
  input  logic                             emit,
  input  swr_pkg::result_t                 res,
  output logic                             space,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [swr_pkg::OUT_DATA_W-1:0]   m_tdata
);

  logic             valid;
  swr_pkg::result_t held;

  assign space    = !valid || m_tready;
  assign m_tvalid = valid;
  assign m_tdata  = {{(swr_pkg::OUT_DATA_W - swr_pkg::OUT_BITS){1'b0}},
                     held.closed, held.delivered_length, held.is_retransmit,
                     held.send_ack, held.send_seq, held.send_flags};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (space && take && emit) begin
      held <= res;
    end
  end

endmodule
